// ----- rtl/core/suve_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suve_pkg
// Shared types, codes and helpers of the scalar voltage estimator.
// ----------------------------------------------------------------------------
package suve_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_CONST    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd3;

	localparam logic [31:0] TAU_RESET = 32'd231000;
	localparam logic [15:0] CW_RESET  = 16'd65470;
	localparam logic [16:0] WGT_ONE   = 17'h10000;

	// Sigma point weights are kept in units of 2^-18.
	localparam int unsigned WGT_SHIFT = 18;
	// The gain division runs on a divisor below 2^40.
	localparam int unsigned NORM_BIT  = 40;

	localparam logic [6:0] DIV_STEPS  = 7'd64;
	localparam logic [6:0] SQRT_STEPS = 7'd32;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

	typedef enum logic [1:0] {
		IT_MUL,
		IT_DIV,
		IT_SQRT
	} it_kind_t;

	typedef struct packed {
		logic     start;
		it_kind_t kind;
	} it_cmd_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD,
		DP_V_START,
		DP_V_DONE,
		DP_S_START,
		DP_S_DONE,
		DP_DEC_MUL,
		DP_DEC_DIV,
		DP_DEC_DONE,
		DP_M0_MUL,
		DP_M0_DONE,
		DP_M1_MUL,
		DP_M1_DONE,
		DP_VA_SQ,
		DP_VA_W,
		DP_VA_DONE,
		DP_NOISE,
		DP_NORM,
		DP_K_START,
		DP_K_DONE,
		DP_E_MUL,
		DP_E_DONE,
		DP_P_MUL,
		DP_P_DONE,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic it_done;
		logic norm_big;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_V, S_V_W,
		S_S, S_S_W,
		S_DM, S_DM_W,
		S_DD, S_DD_W,
		S_M0, S_M0_W,
		S_M1, S_M1_W,
		S_VQ, S_VQ_W,
		S_VW, S_VW_W,
		S_NOISE,
		S_NORM,
		S_K, S_K_W,
		S_E, S_E_W,
		S_P, S_P_W,
		S_OUT
	} ctl_state_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > SAT_MAX) r = 32'h7fff_ffff;
		else if (v < SAT_MIN) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/core/suve_iter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suve_iter
// Iterative arithmetic unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module suve_iter import suve_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  it_cmd_t       cmd,
	input  logic [63:0]   op_a,
	input  logic [63:0]   op_b,
	output logic          done,
	output logic [127:0]  prod,
	output logic [63:0]   quot,
	output logic [31:0]   root
);

	logic        busy_q;
	logic        done_q;
	it_kind_t    kind_q;
	logic [6:0]  cnt_q;
	logic [127:0] acc_q;
	logic [127:0] mcand_q;
	logic [63:0] mplier_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [32:0] srem_q;
	logic [63:0] rad_q;
	logic [31:0] root_q;

	logic        fin;
	logic [64:0] div_try;
	logic        div_fit;
	logic [34:0] sq_try;
	logic [34:0] sq_trial;

	assign fin      = (kind_q == IT_MUL) ? (mplier_q == 64'd0) : (cnt_q == 7'd0);
	assign div_try  = {rem_q, quo_q[63]};
	assign div_fit  = div_try >= {1'b0, dvs_q};
	assign sq_try   = {srem_q, rad_q[63:62]};
	assign sq_trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			kind_q <= IT_MUL;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				kind_q <= cmd.kind;
				cnt_q  <= (cmd.kind == IT_DIV) ? DIV_STEPS : SQRT_STEPS;
			end else if (busy_q) begin
				if (fin) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (kind_q != IT_MUL) begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q    <= '0;
			mcand_q  <= 128'(op_a);
			mplier_q <= op_b;
			rem_q    <= '0;
			quo_q    <= op_a;
			dvs_q    <= op_b;
			srem_q   <= '0;
			rad_q    <= op_a;
			root_q   <= '0;
		end else if (busy_q && !fin) begin
			unique case (kind_q)
				IT_MUL: begin
					if (mplier_q[0]) acc_q <= acc_q + mcand_q;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
				IT_DIV: begin
					if (div_fit) begin
						rem_q <= 64'(div_try - {1'b0, dvs_q});
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= div_try[63:0];
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end
				IT_SQRT: begin
					if (sq_try >= sq_trial) begin
						srem_q <= 33'(sq_try - sq_trial);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						srem_q <= sq_try[32:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					rad_q <= rad_q << 2;
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quot = quo_q;
	assign root = root_q;

endmodule

// ----- rtl/core/suve_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suve_datapath
// Filter state, configuration registers and working registers of one update.
// ----------------------------------------------------------------------------
module suve_datapath import suve_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]          cfg_wdata,
	input  logic [63:0]          s_tdata,
	input  ctl_cmd_t             cmd,
	output dp_stat_t             stat,
	output logic [95:0]          m_tdata
);

	localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
	localparam int unsigned K_W   = FRAC_BITS + 1;

	logic [31:0] q_noise_q, r_noise_q, tau_cfg_q;
	logic [15:0] cw_q;

	logic signed [31:0] est_q, model_q;
	logic [31:0] var_q, last_q;

	logic signed [31:0] z_q;
	logic [31:0] now_q, tau_q;
	logic [32:0] den_q;
	logic [48:0] v_q;
	logic signed [31:0] x1_q, x2_q;
	logic signed [31:0] dec_q [4];
	logic        neg_q;
	logic signed [51:0] acc_q;
	logic signed [31:0] mean_q, est_new_q;
	logic [63:0] sum_q, px_q, sn_q, pn_q;
	logic [K_W-1:0] k_q;
	logic [31:0] est_out_q, var_out_q, model_out_q;

	it_cmd_t      it_cmd;
	logic [63:0]  op_a, op_b;
	logic         it_done;
	logic [127:0] prod;
	logic [63:0]  quot;
	logic [31:0]  root;

	logic [31:0] dt, tau;
	logic [17:0] a0, a1, w_sel;
	logic signed [31:0] src, va_x;
	logic [31:0] src_mag;
	logic signed [32:0] d_va, sx, dz;
	logic [32:0] d_mag, sx_mag, dz_mag;
	logic        clamp;
	logic [32:0] s_val;
	logic signed [33:0] sp, sm;
	logic signed [51:0] m_p, m_t;
	logic signed [63:0] pe, e64;
	logic [63:0] ks, pnew64;

	assign dt  = s_tdata[63:32] - last_q;
	assign tau = (tau_cfg_q == 32'd0) ? 32'd1 : tau_cfg_q;
	assign a0  = {cw_q, 2'b00};
	assign a1  = 18'({1'b0, WGT_ONE} - {2'b00, cw_q});
	assign w_sel = (cmd.idx == 2'd0) ? a0 : a1;

	always_comb begin
		unique case (cmd.idx)
			2'd0: src = model_q;
			2'd1: src = est_q;
			2'd2: src = x1_q;
			2'd3: src = x2_q;
			default: src = model_q;
		endcase
	end
	assign src_mag = src[31] ? 32'(-src) : src;

	assign va_x  = dec_q[2'(cmd.idx + 2'd1)];
	assign d_va  = {va_x[31], va_x} - {mean_q[31], mean_q};
	assign d_mag = d_va[32] ? 33'(-d_va) : d_va;
	assign sx    = {dec_q[2][31], dec_q[2]} + {dec_q[3][31], dec_q[3]};
	assign sx_mag = sx[32] ? 33'(-sx) : sx;
	assign dz    = {z_q[31], z_q} - {mean_q[31], mean_q};
	assign dz_mag = dz[32] ? 33'(-dz) : dz;

	// A spread too large for the root input saturates to 2^32.
	assign clamp = (64'(v_q) >> (64 - FRAC_BITS)) != 64'd0;
	assign s_val = clamp ? {1'b1, 32'd0} : {1'b0, root};
	assign sp    = {{2{est_q[31]}}, est_q} + {1'b0, s_val};
	assign sm    = {{2{est_q[31]}}, est_q} - {1'b0, s_val};

	assign m_p = neg_q ? -$signed(prod[51:0]) : $signed(prod[51:0]);
	assign m_t = acc_q + m_p;
	assign pe  = neg_q ? -$signed(prod[63:0]) : $signed(prod[63:0]);
	assign e64 = $signed({{32{mean_q[31]}}, mean_q}) + (pe >>> FRAC_BITS);
	assign ks  = 64'(prod >> FRAC_BITS);
	assign pnew64 = (ks >= px_q) ? 64'd0 : px_q - ks;

	always_comb begin
		it_cmd.start = 1'b1;
		it_cmd.kind  = IT_MUL;
		op_a = '0;
		op_b = '0;
		unique case (cmd.op)
			DP_V_START: begin
				it_cmd.kind = IT_DIV;
				op_a = {15'd0, var_q, 17'd0};
				op_b = 64'(a1);
			end
			DP_S_START: begin
				it_cmd.kind = IT_SQRT;
				op_a = 64'(v_q) << FRAC_BITS;
			end
			DP_DEC_MUL: begin
				op_a = 64'(src_mag);
				op_b = 64'(tau_q);
			end
			DP_DEC_DIV: begin
				it_cmd.kind = IT_DIV;
				op_a = prod[63:0];
				op_b = 64'(den_q);
			end
			DP_M0_MUL: begin
				op_a = 64'(dec_q[1][31] ? 32'(-dec_q[1]) : dec_q[1]);
				op_b = 64'(a0);
			end
			DP_M1_MUL: begin
				op_a = 64'(sx_mag);
				op_b = 64'(a1);
			end
			DP_VA_SQ: begin
				op_a = 64'(d_mag);
				op_b = 64'(d_mag);
			end
			DP_VA_W: begin
				op_a = 64'(prod >> FRAC_BITS);
				op_b = 64'(w_sel);
			end
			DP_K_START: begin
				it_cmd.kind = IT_DIV;
				op_a = sn_q << FRAC_BITS;
				op_b = pn_q;
			end
			DP_E_MUL: begin
				op_a = 64'(dz_mag);
				op_b = 64'(k_q);
			end
			DP_P_MUL: begin
				op_a = sum_q;
				op_b = 64'(k_q);
			end
			default: it_cmd.start = 1'b0;
		endcase
	end

	suve_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (it_cmd),
		.op_a   (op_a),
		.op_b   (op_b),
		.done   (it_done),
		.prod   (prod),
		.quot   (quot),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= ONE_Q;
			r_noise_q <= ONE_Q;
			tau_cfg_q <= TAU_RESET;
			cw_q      <= CW_RESET;
			est_q     <= '0;
			var_q     <= ONE_Q;
			model_q   <= '0;
			last_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_PROCESS_NOISE: q_noise_q <= cfg_wdata;
					REG_MEAS_NOISE:    r_noise_q <= cfg_wdata;
					REG_TIME_CONST:    tau_cfg_q <= cfg_wdata;
					REG_CENTER_WEIGHT: cw_q      <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (cmd.op == DP_P_DONE) begin
				est_q   <= est_new_q;
				var_q   <= (pnew64[63:32] != 32'd0) ? 32'hffff_ffff : pnew64[31:0];
				model_q <= dec_q[0];
				last_q  <= now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				z_q   <= s_tdata[31:0];
				now_q <= s_tdata[63:32];
				tau_q <= tau;
				den_q <= {1'b0, tau} + {1'b0, dt};
				sum_q <= '0;
			end
			DP_V_DONE: v_q <= quot[48:0];
			DP_S_DONE: begin
				x1_q <= sat32({{30{sp[33]}}, sp});
				x2_q <= sat32({{30{sm[33]}}, sm});
			end
			DP_DEC_MUL: neg_q <= src[31];
			DP_DEC_DONE: dec_q[cmd.idx] <= neg_q ? -$signed(quot[31:0]) : $signed(quot[31:0]);
			DP_M0_MUL: neg_q <= dec_q[1][31];
			DP_M0_DONE: acc_q <= m_p;
			DP_M1_MUL: neg_q <= sx[32];
			DP_M1_DONE: mean_q <= sat32($signed({{12{m_t[51]}}, m_t}) >>> WGT_SHIFT);
			DP_VA_DONE: sum_q <= sum_q + 64'(prod >> WGT_SHIFT);
			DP_NOISE: begin
				px_q <= sum_q + 64'(q_noise_q);
				sn_q <= sum_q;
				pn_q <= sum_q + 64'(r_noise_q);
			end
			DP_NORM: begin
				sn_q <= sn_q >> 1;
				pn_q <= pn_q >> 1;
			end
			DP_K_DONE: k_q <= (pn_q == 64'd0) ? '0 : quot[K_W-1:0];
			DP_E_MUL: neg_q <= dz[32];
			DP_E_DONE: est_new_q <= sat32(e64);
			DP_OUT: begin
				est_out_q   <= est_q;
				var_out_q   <= var_q;
				model_out_q <= model_q;
			end
			default: ;
		endcase
	end

	assign stat.it_done  = it_done;
	assign stat.norm_big = pn_q[63:NORM_BIT] != '0;
	assign m_tdata = {model_out_q, var_out_q, est_out_q};

endmodule

// ----- rtl/core/suve_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suve_ctrl
// Sequencer of one filter update and owner of the result valid flag.
// ----------------------------------------------------------------------------
module suve_ctrl import suve_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic [1:0] idx_q, idx_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_V;
			S_V:     state_d = S_V_W;
			S_V_W:   if (stat.it_done) state_d = S_S;
			S_S:     state_d = S_S_W;
			S_S_W:   if (stat.it_done) begin
				state_d = S_DM;
				idx_d   = 2'd0;
			end
			S_DM:    state_d = S_DM_W;
			S_DM_W:  if (stat.it_done) state_d = S_DD;
			S_DD:    state_d = S_DD_W;
			S_DD_W:  if (stat.it_done) begin
				if (idx_q == 2'd3) begin
					state_d = S_M0;
				end else begin
					state_d = S_DM;
					idx_d   = idx_q + 2'd1;
				end
			end
			S_M0:    state_d = S_M0_W;
			S_M0_W:  if (stat.it_done) state_d = S_M1;
			S_M1:    state_d = S_M1_W;
			S_M1_W:  if (stat.it_done) begin
				state_d = S_VQ;
				idx_d   = 2'd0;
			end
			S_VQ:    state_d = S_VQ_W;
			S_VQ_W:  if (stat.it_done) state_d = S_VW;
			S_VW:    state_d = S_VW_W;
			S_VW_W:  if (stat.it_done) begin
				if (idx_q == 2'd2) begin
					state_d = S_NOISE;
				end else begin
					state_d = S_VQ;
					idx_d   = idx_q + 2'd1;
				end
			end
			S_NOISE: state_d = S_NORM;
			S_NORM:  if (!stat.norm_big) state_d = S_K;
			S_K:     state_d = S_K_W;
			S_K_W:   if (stat.it_done) state_d = S_E;
			S_E:     state_d = S_E_W;
			S_E_W:   if (stat.it_done) state_d = S_P;
			S_P:     state_d = S_P_W;
			S_P_W:   if (stat.it_done) state_d = S_OUT;
			S_OUT:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op  = DP_NONE;
		cmd.idx = idx_q;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) cmd.op = DP_LOAD;
			end
			S_V:     cmd.op = DP_V_START;
			S_V_W:   if (stat.it_done) cmd.op = DP_V_DONE;
			S_S:     cmd.op = DP_S_START;
			S_S_W:   if (stat.it_done) cmd.op = DP_S_DONE;
			S_DM:    cmd.op = DP_DEC_MUL;
			S_DD:    cmd.op = DP_DEC_DIV;
			S_DD_W:  if (stat.it_done) cmd.op = DP_DEC_DONE;
			S_M0:    cmd.op = DP_M0_MUL;
			S_M0_W:  if (stat.it_done) cmd.op = DP_M0_DONE;
			S_M1:    cmd.op = DP_M1_MUL;
			S_M1_W:  if (stat.it_done) cmd.op = DP_M1_DONE;
			S_VQ:    cmd.op = DP_VA_SQ;
			S_VW:    cmd.op = DP_VA_W;
			S_VW_W:  if (stat.it_done) cmd.op = DP_VA_DONE;
			S_NOISE: cmd.op = DP_NOISE;
			S_NORM:  if (stat.norm_big) cmd.op = DP_NORM;
			S_K:     cmd.op = DP_K_START;
			S_K_W:   if (stat.it_done) cmd.op = DP_K_DONE;
			S_E:     cmd.op = DP_E_MUL;
			S_E_W:   if (stat.it_done) cmd.op = DP_E_DONE;
			S_P:     cmd.op = DP_P_MUL;
			S_P_W:   if (stat.it_done) cmd.op = DP_P_DONE;
			S_OUT:   if (out_free) cmd.op = DP_OUT;
			default: cmd.op = DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.op == DP_OUT) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.it_done |-> (state_q == S_V_W || state_q == S_S_W || state_q == S_DM_W ||
			state_q == S_DD_W || state_q == S_M0_W || state_q == S_M1_W ||
			state_q == S_VQ_W || state_q == S_VW_W || state_q == S_K_W ||
			state_q == S_E_W || state_q == S_P_W))
		else $error("arithmetic unit finished outside a wait state");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result register not loaded on leaving the output state");
	a_var_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VQ || state_q == S_VW) |-> idx_q != 2'd3)
		else $error("variance step index out of range");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == S_V)
		else $error("accepted item did not start an update");
`endif

endmodule

// ----- rtl/core/scalar_ukf_voltage_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_ukf_voltage_estimator
// Scalar unscented Kalman filter for a battery voltage in signed fixed point.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (lowest bits first)
//  cfg      in         register index, 32-bit write data
//  s_*      in         measured_voltage, sample_time_ms
//  m_*      out        voltage_estimate, estimate_covariance, model_voltage
//
// Each update is built on the shared iterative unit, which retires one bit
// per cycle: six 64-step divides, a 32-step square root, and shift-add
// multiplies whose length follows the bit length of the second operand.
// Reset is asynchronous and active low; the filter state returns to zero
// estimate, unit variance and zero timestamp, and the registers to defaults.
// A stalled result register holds its item while the next item is accepted
// and processed; only the final load waits for the result register to drain.
//
// Each update decays the model voltage and three sigma points through the
// RC model v*tau/(tau+dt), forms their weighted mean and spread, and applies
// the Kalman gain. The timestamp of each item is kept for the next dt.
// ----------------------------------------------------------------------------
module scalar_ukf_voltage_estimator import suve_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [31:0]          cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [31:0] measured_voltage, [63:32] sample_time_ms
	input  logic [63:0]          s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [31:0] voltage_estimate, [63:32] estimate_covariance, [95:64] model_voltage
	output logic [95:0]          m_tdata
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// The sequencer walks the update step by step and tells the datapath
	// which working registers to load or which unit operation to launch.
	suve_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the filter state, the configuration and the result.
	suve_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tdata   (m_tdata)
	);

endmodule
